@@ rtl/aces_tonemap_gamma_quantize_top_macros.svh @@
// Assertion helpers used by the checker atgq_chk.
`ifndef ACES_TONEMAP_GAMMA_QUANTIZE_TOP_MACROS_SVH
`define ACES_TONEMAP_GAMMA_QUANTIZE_TOP_MACROS_SVH

// Implication check, sampled on clk, off while rst_n is low.
`define ATGQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must never be seen out of reset.
`define ATGQ_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

@@ rtl/atgq_pkg.sv @@
`default_nettype none

package atgq_pkg;

  localparam int InW   = 16;  // linear channel width
  localparam int CodeW = 8;   // display code width
  localparam int CoefW = 18;  // Q16 curve coefficients
  localparam int GamW  = 192; // exact compare width for the gamma table

  // Fitted ACES curve coefficients, Q16, rounded to nearest.
  localparam logic [CoefW-1:0] CoA = 18'd164495; // 2.51
  localparam logic [CoefW-1:0] CoB = 18'd1966;   // 0.03
  localparam logic [CoefW-1:0] CoC = 18'd159252; // 2.43
  localparam logic [CoefW-1:0] CoD = 18'd38666;  // 0.59
  localparam logic [CoefW-1:0] CoE = 18'd9175;   // 0.14

  localparam int CodeMax  = 255;
  localparam int GammaNum = 5;   // 1/2.2 = 5/11
  localparam int GammaDen = 11;

  // Width of the saturated input.
  function automatic int x_width(input int frac_bits, input int int_bits);
    return (frac_bits + int_bits < InW) ? frac_bits + int_bits : InW;
  endfunction

  // Width of the first-order terms pn, pd.
  function automatic int p_width(input int frac_bits, input int int_bits);
    return CoefW + x_width(frac_bits, int_bits) - frac_bits + 1;
  endfunction

  // Largest k with k^11 * 2^(5g) <= q^5 * 255^11, i.e. floor(255 * (q/2^g)^(5/11)).
  function automatic logic [CodeW-1:0] gamma_code(input int unsigned q, input int unsigned g);
    logic [GamW-1:0]  rhs;
    logic [GamW-1:0]  lhs;
    logic [CodeW-1:0] k;
    logic [CodeW-1:0] cand;
    int               i;
    int               b;
    rhs = GamW'(1);
    for (i = 0; i < GammaNum; i++) rhs = rhs * GamW'(q);
    for (i = 0; i < GammaDen; i++) rhs = rhs * GamW'(CodeMax);
    k = '0;
    for (b = CodeW - 1; b >= 0; b--) begin
      cand = k | (CodeW'(1) << b);
      lhs  = GamW'(1);
      for (i = 0; i < GammaDen; i++) lhs = lhs * GamW'(cand);
      lhs = lhs << (GammaNum * g);
      if (lhs <= rhs) k = cand;
    end
    return k;
  endfunction

endpackage

`default_nettype wire

@@ rtl/aces_tonemap_gamma_quantize_top.sv @@
`default_nettype none

// ACES filmic tonemap + gamma 1/2.2 + 8-bit quantize, one RGB pixel per beat.
// A pixel is taken on any clock edge where start is high and busy is low;
// busy is high only while rst_n is held, so out of reset a new pixel can be
// started on every cycle with no gaps. Its codes come out on out_disp_*,
// each pixel's three codes together, marked by out_valid
// for exactly one cycle. There is no backpressure: the receiver must take each
// beat in the cycle it appears, since the pipeline never stalls and the next
// pixel's result follows right behind. Results keep input order, one per pixel.
// Per channel: the input (UQ IN_INT_BITS.IN_FRAC_BITS, 2^IN_FRAC_BITS = 1.0)
// saturates at its top code, the fitted curve x(2.51x+0.03)/(x(2.43x+0.59)+0.14)
// is evaluated in Q16 fixed point over two multiply stages, the ratio is found
// by a restoring divider that resolves one quotient bit per stage (plus a
// front stage that catches ratios of 1.0 and above), and the clamped ratio
// indexes a gamma ROM whose registered read is the output register. The
// divider has GAMMA_INDEX_BITS bit stages after its front stage; throughput
// is one pixel per clock. No configuration, no state beyond the pipeline.
module aces_tonemap_gamma_quantize_top import atgq_pkg::*; #(
  parameter int IN_FRAC_BITS = 12,
  parameter int IN_INT_BITS = 4,
  parameter int GAMMA_INDEX_BITS = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [InW-1:0]   in_lin_red,
  input  logic [InW-1:0]   in_lin_green,
  input  logic [InW-1:0]   in_lin_blue,
  output logic             out_valid,
  output logic [CodeW-1:0] out_disp_red,
  output logic [CodeW-1:0] out_disp_green,
  output logic [CodeW-1:0] out_disp_blue
);

  localparam int XW    = x_width(IN_FRAC_BITS, IN_INT_BITS);
  localparam int PW    = p_width(IN_FRAC_BITS, IN_INT_BITS);
  localparam int NumW  = XW + PW;
  localparam int DenW  = NumW + 1;
  localparam int NChan = 3;
  // curve (2) + divider front (1) + divider bits (G) + ROM read (1)
  localparam int Lat   = GAMMA_INDEX_BITS + 4;

  logic             accept;
  logic [Lat-1:0]   vld_r;
  logic [Lat-1:0]   vld_nxt;

  logic [InW-1:0]          lin_w  [NChan];
  logic [NumW-1:0]         num_w  [NChan];
  logic [DenW-1:0]         den_w  [NChan];
  logic [GAMMA_INDEX_BITS:0] quo_w [NChan];
  logic [CodeW-1:0]        code_w [NChan];

  // only reset holds off new pixels
  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  // valid bit rides alongside the data through every stage
  assign vld_nxt = {vld_r[Lat-2:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign lin_w[0] = in_lin_red;
  assign lin_w[1] = in_lin_green;
  assign lin_w[2] = in_lin_blue;

  for (genvar c = 0; c < NChan; c++) begin : g_chan
    atgq_curve #(
      .FracBits(IN_FRAC_BITS),
      .IntBits (IN_INT_BITS)
    ) u_curve (
      .clk  (clk),
      .lin  (lin_w[c]),
      .num_r(num_w[c]),
      .den_r(den_w[c])
    );

    atgq_div #(
      .NumW(NumW),
      .QW  (GAMMA_INDEX_BITS)
    ) u_div (
      .clk(clk),
      .num(num_w[c]),
      .den(den_w[c]),
      .quo(quo_w[c])
    );

    atgq_gamma #(
      .G(GAMMA_INDEX_BITS)
    ) u_gamma (
      .clk   (clk),
      .idx   (quo_w[c]),
      .code_r(code_w[c])
    );
  end

  assign out_valid      = vld_r[Lat-1];
  assign out_disp_red   = code_w[0];
  assign out_disp_green = code_w[1];
  assign out_disp_blue  = code_w[2];

endmodule

`default_nettype wire

@@ rtl/atgq_curve.sv @@
`default_nettype none

// Two stages: saturate and first-order terms, then numerator and denominator.
module atgq_curve import atgq_pkg::*; #(
  parameter int FracBits = 12,
  parameter int IntBits = 4,
  localparam int XW = x_width(FracBits, IntBits),
  localparam int PW = p_width(FracBits, IntBits),
  localparam int NumW = XW + PW,
  localparam int DenW = NumW + 1
) (
  input  logic            clk,
  input  logic [InW-1:0]  lin,
  output logic [NumW-1:0] num_r,
  output logic [DenW-1:0] den_r
);

  localparam int MulW  = CoefW + XW;
  localparam int ProdW = MulW + 1;

  logic [XW-1:0]    xs;
  logic [MulW-1:0]  pn_prod;
  logic [MulW-1:0]  pd_prod;
  logic [ProdW-1:0] pn_sum;
  logic [ProdW-1:0] pd_sum;
  logic [XW-1:0]    xs_r;
  logic [PW-1:0]    pn_r;
  logic [PW-1:0]    pd_r;
  logic [NumW-1:0]  num_nxt;
  logic [NumW-1:0]  xpd;
  logic [DenW-1:0]  den_nxt;

  // clamp to the largest code of the input format
  if (XW < InW) begin : g_sat
    assign xs = (|lin[InW-1:XW]) ? {XW{1'b1}} : lin[XW-1:0];
  end else begin : g_pass
    assign xs = lin[XW-1:0];
  end

  assign pn_prod = MulW'(CoA) * MulW'(xs);
  assign pd_prod = MulW'(CoC) * MulW'(xs);
  assign pn_sum  = ProdW'(pn_prod) + (ProdW'(CoB) << FracBits);
  assign pd_sum  = ProdW'(pd_prod) + (ProdW'(CoD) << FracBits);

  always_ff @(posedge clk) begin
    xs_r <= xs;
    pn_r <= pn_sum[ProdW-1:FracBits];
    pd_r <= pd_sum[ProdW-1:FracBits];
  end

  assign num_nxt = NumW'(xs_r) * NumW'(pn_r);
  assign xpd     = NumW'(xs_r) * NumW'(pd_r);
  assign den_nxt = DenW'(xpd) + (DenW'(CoE) << FracBits);

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    den_r <= den_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/atgq_div.sv @@
`default_nettype none

// Pipelined restoring divider: floor(num * 2^QW / den), saturated at 2^QW.
// Front stage flags num >= den; then one quotient bit per stage.
module atgq_div import atgq_pkg::*; #(
  parameter int NumW = 38,
  parameter int QW = 12,
  localparam int DenW = NumW + 1
) (
  input  logic            clk,
  input  logic [NumW-1:0] num,
  input  logic [DenW-1:0] den,
  output logic [QW:0]     quo
);

  typedef struct packed {
    logic [DenW-1:0] rem;
    logic [DenW-1:0] dvs;
    logic [QW-1:0]   bits;
    logic            sat;
  } dstage_t;

  dstage_t stage_r   [QW+1];
  dstage_t stage_nxt [QW+1];

  always_comb begin
    logic [DenW:0] shl;
    logic          ge;
    stage_nxt[0].sat  = {1'b0, num} >= den;
    stage_nxt[0].rem  = stage_nxt[0].sat ? '0 : DenW'(num);
    stage_nxt[0].dvs  = den;
    stage_nxt[0].bits = '0;
    for (int j = 1; j <= QW; j++) begin
      shl = {stage_r[j-1].rem, 1'b0};
      ge  = shl >= {1'b0, stage_r[j-1].dvs};
      stage_nxt[j].rem  = ge ? DenW'(shl - {1'b0, stage_r[j-1].dvs}) : DenW'(shl);
      stage_nxt[j].dvs  = stage_r[j-1].dvs;
      stage_nxt[j].bits = {stage_r[j-1].bits[QW-2:0], ge};
      stage_nxt[j].sat  = stage_r[j-1].sat;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j <= QW; j++) stage_r[j] <= stage_nxt[j];
  end

  assign quo = stage_r[QW].sat ? ((QW+1)'(1) << QW) : {1'b0, stage_r[QW].bits};

endmodule

`default_nettype wire

@@ rtl/atgq_gamma.sv @@
`default_nettype none

// Gamma 1/2.2 ROM, 2^G + 1 entries, contents built at elaboration.
module atgq_gamma import atgq_pkg::*; #(
  parameter int G = 12,
  localparam int IdxW = G + 1,
  localparam int Depth = (1 << G) + 1
) (
  input  logic             clk,
  input  logic [IdxW-1:0]  idx,
  output logic [CodeW-1:0] code_r
);

  logic [CodeW-1:0] rom_w [Depth];

  for (genvar gi = 0; gi < Depth; gi++) begin : g_rom
    localparam logic [CodeW-1:0] Code = gamma_code(gi, G);
    assign rom_w[gi] = Code;
  end

  always_ff @(posedge clk) begin
    code_r <= rom_w[idx];
  end

endmodule

`default_nettype wire

@@ rtl/atgq_chk.sv @@
`default_nettype none

`include "aces_tonemap_gamma_quantize_top_macros.svh"

// Port-level checks on the tonemapper; Lat is the fixed pipeline latency.
module atgq_chk import atgq_pkg::*; #(
  parameter int Lat = 16
) (
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic [InW-1:0]   in_lin_red,
  input logic [InW-1:0]   in_lin_green,
  input logic [InW-1:0]   in_lin_blue,
  input logic             out_valid,
  input logic [CodeW-1:0] out_disp_red,
  input logic [CodeW-1:0] out_disp_green,
  input logic [CodeW-1:0] out_disp_blue
);

  // sampled rst_n keeps the release edge itself out of the check
  `ATGQ_ASSERT_NEVER(a_no_busy, busy && rst_n, "busy raised out of reset")

  `ATGQ_ASSERT_IMP(a_beat_out, start && !busy, ##Lat out_valid, "accepted beat lost")

  `ATGQ_ASSERT_IMP(a_no_extra, out_valid, $past(start && !busy, Lat),
                   "result beat without input")

  `ATGQ_ASSERT_IMP(a_chan_match, start && !busy && in_lin_red == in_lin_green,
                   ##Lat (out_disp_red == out_disp_green), "equal channels differ")

  `ATGQ_ASSERT_IMP(a_black, start && !busy && in_lin_blue == '0,
                   ##Lat (out_disp_blue == '0), "black input not black")

endmodule

bind aces_tonemap_gamma_quantize_top atgq_chk #(
  .Lat(GAMMA_INDEX_BITS + 4)
) u_atgq_chk (.*);

`default_nettype wire
